// ===== src/ursr_pkg.sv =====
// Shared types, constants and helper functions for the ultrasonic ranger core.
// Used by ursr_seq, ursr_out and ultrasonic_ranger_seven_segment_core.
package ursr_pkg;

   // sequencer phases, one-hot
   typedef enum logic [3:0] {
      PH_DISPLAY   = 4'b0001,
      PH_TRIGGER   = 4'b0010,
      PH_WAIT_HIGH = 4'b0100,
      PH_WAIT_LOW  = 4'b1000
   } phase_type;

   // configuration register indexes
   localparam logic [1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_TRIGGER = 2'd1;
   localparam logic [1:0] CSR_DIGIT   = 2'd2;
   localparam logic [1:0] CSR_PASSES  = 2'd3;

   localparam logic [15:0] TIMEOUT_RESET = 16'd30000;
   localparam logic [7:0]  TRIGGER_RESET = 8'd10;
   localparam logic [15:0] DIGIT_RESET   = 16'd2000;
   localparam logic [3:0]  PASSES_RESET  = 4'd10;

   localparam logic [13:0] MAX_HUNDREDTHS = 14'd9999;
   localparam logic [15:0] MAX_BCD        = 16'h9999;
   localparam logic [7:0]  DP_BIT         = 8'h80;
   localparam logic [7:0]  DASH_SEG       = 8'h40;
   localparam logic [1:0]  DP_DIGIT       = 2'd2;
   localparam logic [1:0]  LAST_DIGIT     = 2'd3;

   // 1715/1000 per microsecond = 1 whole step plus 715/1000 remainder
   localparam logic [10:0] REM_STEP = 11'd715;
   localparam logic [10:0] REM_BASE = 11'd1000;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  trigger_ticks;
      logic [15:0] digit_ticks;
      logic [3:0]  passes_per_measure;
   } cfg_type;

   // sequencer state seen by the display decode
   typedef struct packed {
      phase_type   phase;
      logic [1:0]  digit_index;
      logic [13:0] shown_bin;
      logic [15:0] shown_bcd;
      logic        error_flag;
   } seq_view_type;

   // seven-segment font, segments a..g in bits 0..6
   function automatic logic [7:0] digit_font(input logic [3:0] d);
      logic [7:0] pat;
      case (d)
         4'd0: pat = 8'h3F;
         4'd1: pat = 8'h06;
         4'd2: pat = 8'h5B;
         4'd3: pat = 8'h4F;
         4'd4: pat = 8'h66;
         4'd5: pat = 8'h6D;
         4'd6: pat = 8'h7D;
         4'd7: pat = 8'h07;
         4'd8: pat = 8'h7F;
         4'd9: pat = 8'h6F;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   // add a small increment (1 or 2) to a four-digit bcd value
   function automatic logic [15:0] bcd_add(input logic [15:0] v, input logic [1:0] inc);
      logic [15:0] res;
      logic [4:0]  sum;
      logic [1:0]  carry;
      res   = '0;
      carry = inc;
      for (int i = 0; i < 4; i++) begin
         sum = {1'b0, v[i*4 +: 4]} + {3'b000, carry};
         if (sum >= 5'd10) begin
            res[i*4 +: 4] = 4'(sum - 5'd10);
            carry = 2'd1;
         end else begin
            res[i*4 +: 4] = sum[3:0];
            carry = 2'd0;
         end
      end
      return res;
   endfunction

endpackage

// ===== src/ultrasonic_ranger_seven_segment_core.sv =====
// Ultrasonic echo ranger with four-digit multiplexed seven-segment display.
// Each accepted request has its registered response valid in the next cycle.
// Throughput: one request per cycle; a new request is taken while the
// response register is being read, and held off only while it stays stalled.
// Reset (synchronous, active high): display phase, counters and distance
// cleared, registers at their defaults, no response pending.
module ultrasonic_ranger_seven_segment_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_echo_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_trigger_out,
   output logic [7:0]  rsp_segments,
   output logic [3:0]  rsp_digit_enable_n,
   output logic [13:0] rsp_distance_hundredths,
   output logic        rsp_timed_out
);

   ursr_pkg::cfg_type      cfg_ff;
   ursr_pkg::seq_view_type view;
   logic                   accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks      <= ursr_pkg::TIMEOUT_RESET;
         cfg_ff.trigger_ticks      <= ursr_pkg::TRIGGER_RESET;
         cfg_ff.digit_ticks        <= ursr_pkg::DIGIT_RESET;
         cfg_ff.passes_per_measure <= ursr_pkg::PASSES_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ursr_pkg::CSR_TIMEOUT: cfg_ff.timeout_ticks      <= csr_wdata;
            ursr_pkg::CSR_TRIGGER: cfg_ff.trigger_ticks      <= csr_wdata[7:0];
            ursr_pkg::CSR_DIGIT:   cfg_ff.digit_ticks        <= csr_wdata;
            ursr_pkg::CSR_PASSES:  cfg_ff.passes_per_measure <= csr_wdata[3:0];
            default:               cfg_ff.timeout_ticks      <= cfg_ff.timeout_ticks;
         endcase
      end
   end

   // request handshake
   assign req_stall = rsp_valid & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   ursr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .echo_level (req_echo_level),
      .cfg        (cfg_ff),
      .view       (view)
   );

   ursr_out u_out (
      .clock                   (clock),
      .reset                   (reset),
      .load                    (accept),
      .view                    (view),
      .rsp_stall               (rsp_stall),
      .rsp_valid               (rsp_valid),
      .rsp_trigger_out         (rsp_trigger_out),
      .rsp_segments            (rsp_segments),
      .rsp_digit_enable_n      (rsp_digit_enable_n),
      .rsp_distance_hundredths (rsp_distance_hundredths),
      .rsp_timed_out           (rsp_timed_out)
   );

endmodule

// ===== src/ursr_seq.sv =====
// Measurement sequencer: display multiplexing, trigger pulse, echo timing.
// Depends on ursr_pkg; advances once per accepted request.
module ursr_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   echo_level,
   input  ursr_pkg::cfg_type      cfg,
   output ursr_pkg::seq_view_type view
);

   ursr_pkg::phase_type phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [1:0]  digit_ff, digit_in;
   logic [3:0]  pass_ff, pass_in;
   logic [13:0] shown_bin_ff, shown_bin_in;
   logic [15:0] shown_bcd_ff, shown_bcd_in;
   logic        error_ff, error_in;
   // running distance of the echo being timed
   logic [13:0] meas_bin_ff, meas_bin_in;
   logic [15:0] meas_bcd_ff, meas_bcd_in;
   logic [9:0]  meas_rem_ff, meas_rem_in;

   logic [15:0] timeout_lim, digit_lim;
   logic [7:0]  trigger_lim;
   logic [3:0]  passes_lim;
   logic [16:0] tick_inc;
   logic [4:0]  pass_inc;
   logic [10:0] rem_sum;
   logic        rem_carry;
   logic [1:0]  q_step;
   logic [14:0] q_sum;
   logic [13:0] acc_bin;
   logic [15:0] acc_bcd;
   logic [9:0]  acc_rem;

   // zero-valued registers act as one
   assign timeout_lim = (cfg.timeout_ticks == '0) ? 16'd1 : cfg.timeout_ticks;
   assign digit_lim   = (cfg.digit_ticks == '0) ? 16'd1 : cfg.digit_ticks;
   assign trigger_lim = (cfg.trigger_ticks == '0) ? 8'd1 : cfg.trigger_ticks;
   assign passes_lim  = (cfg.passes_per_measure == '0) ? 4'd1 : cfg.passes_per_measure;

   assign tick_inc = {1'b0, tick_ff} + 17'd1;
   assign pass_inc = {1'b0, pass_ff} + 5'd1;

   // one more echo microsecond: add 1.715 hundredths, saturate at full scale
   always_comb begin
      rem_sum   = {1'b0, meas_rem_ff} + ursr_pkg::REM_STEP;
      rem_carry = (rem_sum >= ursr_pkg::REM_BASE);
      acc_rem   = rem_carry ? 10'(rem_sum - ursr_pkg::REM_BASE) : rem_sum[9:0];
      q_step    = rem_carry ? 2'd2 : 2'd1;
      q_sum     = {1'b0, meas_bin_ff} + {13'd0, q_step};
      if (q_sum > {1'b0, ursr_pkg::MAX_HUNDREDTHS}) begin
         acc_bin = ursr_pkg::MAX_HUNDREDTHS;
         acc_bcd = ursr_pkg::MAX_BCD;
      end else begin
         acc_bin = q_sum[13:0];
         acc_bcd = ursr_pkg::bcd_add(meas_bcd_ff, q_step);
      end
   end

   // next-state logic
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      digit_in     = digit_ff;
      pass_in      = pass_ff;
      shown_bin_in = shown_bin_ff;
      shown_bcd_in = shown_bcd_ff;
      error_in     = error_ff;
      meas_bin_in  = meas_bin_ff;
      meas_bcd_in  = meas_bcd_ff;
      meas_rem_in  = meas_rem_ff;
      case (phase_ff)
         ursr_pkg::PH_DISPLAY: begin
            if (tick_inc >= {1'b0, digit_lim}) begin
               tick_in = '0;
               if (digit_ff == ursr_pkg::LAST_DIGIT) begin
                  digit_in = '0;
                  if (pass_inc >= {1'b0, passes_lim}) begin
                     pass_in  = '0;
                     phase_in = ursr_pkg::PH_TRIGGER;
                  end else begin
                     pass_in = pass_inc[3:0];
                  end
               end else begin
                  digit_in = digit_ff + 2'd1;
               end
            end else begin
               tick_in = tick_inc[15:0];
            end
         end
         ursr_pkg::PH_TRIGGER: begin
            if (tick_inc >= {9'd0, trigger_lim}) begin
               tick_in  = '0;
               phase_in = ursr_pkg::PH_WAIT_HIGH;
            end else begin
               tick_in = tick_inc[15:0];
            end
         end
         ursr_pkg::PH_WAIT_HIGH: begin
            if (echo_level) begin
               tick_in     = 16'd1;
               meas_bin_in = 14'd1;
               meas_bcd_in = 16'h0001;
               meas_rem_in = ursr_pkg::REM_STEP[9:0];
               phase_in    = ursr_pkg::PH_WAIT_LOW;
            end else begin
               tick_in = tick_inc[15:0];
            end
            if ((echo_level && timeout_lim == 16'd1) ||
                (!echo_level && tick_inc >= {1'b0, timeout_lim})) begin
               phase_in     = ursr_pkg::PH_DISPLAY;
               tick_in      = '0;
               digit_in     = '0;
               pass_in      = '0;
               shown_bin_in = '0;
               shown_bcd_in = '0;
               error_in     = 1'b1;
            end
         end
         ursr_pkg::PH_WAIT_LOW: begin
            if (echo_level) begin
               tick_in     = tick_inc[15:0];
               meas_bin_in = acc_bin;
               meas_bcd_in = acc_bcd;
               meas_rem_in = acc_rem;
               if (tick_inc >= {1'b0, timeout_lim}) begin
                  phase_in     = ursr_pkg::PH_DISPLAY;
                  tick_in      = '0;
                  digit_in     = '0;
                  pass_in      = '0;
                  shown_bin_in = '0;
                  shown_bcd_in = '0;
                  error_in     = 1'b1;
               end
            end else begin
               // echo fell: latch the measured distance
               phase_in     = ursr_pkg::PH_DISPLAY;
               tick_in      = '0;
               digit_in     = '0;
               pass_in      = '0;
               shown_bin_in = meas_bin_ff;
               shown_bcd_in = meas_bcd_ff;
               error_in     = 1'b0;
            end
         end
         default: begin
            phase_in = ursr_pkg::PH_DISPLAY;
            tick_in  = '0;
            digit_in = '0;
            pass_in  = '0;
         end
      endcase
   end

   // control and shown-value registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ursr_pkg::PH_DISPLAY;
         tick_ff      <= '0;
         digit_ff     <= '0;
         pass_ff      <= '0;
         shown_bin_ff <= '0;
         shown_bcd_ff <= '0;
         error_ff     <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         digit_ff     <= digit_in;
         pass_ff      <= pass_in;
         shown_bin_ff <= shown_bin_in;
         shown_bcd_ff <= shown_bcd_in;
         error_ff     <= error_in;
      end
   end

   // measurement accumulator, loaded when the echo rises and advanced while it stays high
   always_ff @(posedge clock) begin
      if (step) begin
         meas_bin_ff <= meas_bin_in;
         meas_bcd_ff <= meas_bcd_in;
         meas_rem_ff <= meas_rem_in;
      end
   end

   assign view.phase       = phase_ff;
   assign view.digit_index = digit_ff;
   assign view.shown_bin   = shown_bin_ff;
   assign view.shown_bcd   = shown_bcd_ff;
   assign view.error_flag  = error_ff;

endmodule

// ===== src/ursr_out.sv =====
// Display decode and result register with valid/stall handshake.
// Depends on ursr_pkg; fed by the sequencer view before its update.
module ursr_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ursr_pkg::seq_view_type view,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   rsp_trigger_out,
   output logic [7:0]             rsp_segments,
   output logic [3:0]             rsp_digit_enable_n,
   output logic [13:0]            rsp_distance_hundredths,
   output logic                   rsp_timed_out
);

   logic        valid_ff, valid_in;
   logic        trig_ff, trig_in;
   logic [7:0]  segs_ff, segs_in;
   logic [3:0]  en_n_ff, en_n_in;
   logic [13:0] dist_ff;
   logic        tout_ff;
   logic [3:0]  cur_digit;

   assign cur_digit = view.shown_bcd[{view.digit_index, 2'b00} +: 4];

   // segment and digit-enable decode from the current state
   always_comb begin
      trig_in = 1'b0;
      segs_in = '0;
      en_n_in = 4'hF;
      case (view.phase)
         ursr_pkg::PH_DISPLAY: begin
            segs_in = view.error_flag ? ursr_pkg::DASH_SEG : ursr_pkg::digit_font(cur_digit);
            if (view.digit_index == ursr_pkg::DP_DIGIT) begin
               segs_in = segs_in | ursr_pkg::DP_BIT;
            end
            en_n_in = ~(4'b0001 << view.digit_index);
         end
         ursr_pkg::PH_TRIGGER: begin
            trig_in = 1'b1;
         end
         default: begin
            trig_in = 1'b0;
         end
      endcase
   end

   // result valid holds while stalled
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         trig_ff <= trig_in;
         segs_ff <= segs_in;
         en_n_ff <= en_n_in;
         dist_ff <= view.shown_bin;
         tout_ff <= view.error_flag;
      end
   end

   assign rsp_valid               = valid_ff;
   assign rsp_trigger_out         = trig_ff;
   assign rsp_segments            = segs_ff;
   assign rsp_digit_enable_n      = en_n_ff;
   assign rsp_distance_hundredths = dist_ff;
   assign rsp_timed_out           = tout_ff;

endmodule
